[sv/cwnd_pkg.sv]
// ----------------------------------------------------------------------------
// cwnd_pkg: shared types and constants
// Event codes, register indexes, queue entry and result layouts for the
// window controller.
// ----------------------------------------------------------------------------
`default_nettype none
package cwnd_pkg;
   localparam logic [1:0] CMD_ACK     = 2'd0;
   localparam logic [1:0] CMD_TIMEOUT = 2'd1;
   localparam logic [1:0] CMD_FIRST   = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   localparam logic [2:0] REG_BASE_RTT   = 3'd0;
   localparam logic [2:0] REG_DELAY_THR  = 3'd1;
   localparam logic [2:0] REG_INC_GAIN   = 3'd2;
   localparam logic [2:0] REG_DELAY_DEC  = 3'd3;
   localparam logic [2:0] REG_ECN_GAIN   = 3'd4;
   localparam logic [2:0] REG_EWMA_WT    = 3'd5;
   localparam logic [2:0] REG_TO_HOLDOFF = 3'd6;
   localparam logic [2:0] REG_DETECT     = 3'd7;

   localparam logic [16:0] Q16_ONE = 17'h10000;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // classified event handed from front to back
   typedef struct packed {
      logic [1:0]  cmd;
      logic [47:0] now_time;
      logic        ecn_mark;
      logic [47:0] rtt_sample;
      logic [15:0] acked_bytes;
   } event_type;

   typedef struct packed {
      logic [23:0] window_bytes;
      logic [23:0] slow_start_threshold;
      logic        in_slow_start;
      logic [16:0] ecn_ewma_q16;
      logic        window_cut;
   } result_type;
endpackage
`default_nettype wire

[sv/cwnd_if.sv]
// ----------------------------------------------------------------------------
// cwnd_if: valid/ready channel
// Generic word channel with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none
interface cwnd_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/cwnd_delay_ecn_aimd_controller_unit.sv]
// ----------------------------------------------------------------------------
// cwnd_delay_ecn_aimd_controller_unit: delay/ECN AIMD window controller
// Front end takes event words into a short queue; back end updates the
// window state and returns one result word per event.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | cmd, now_time, ecn_mark, rtt_sample, acked_bytes
//  rsp     | out | window_bytes, slow_start_threshold, in_slow_start,
//          |     | ecn_ewma_q16, window_cut
//  csr     | in  | index (3b), data (48b)
//
// Path, req accept to rsp valid: timeout/first-window/unknown events go to the
// output step; an ACK takes the round, RTT and grow steps, plus a cut step when
// it cuts the window. The end-of-round fraction (with the EWMA steps) and AIMD
// increase each add a pass through the 48-bit serial divider.
// Reset: synchronous; window = MSS, threshold = CWND_MAX, slow start.
// Stalls: the 2-word queue keeps req ready while the engine works until both
// entries are full; the engine runs on while one result word waits in the rsp
// register and holds in its output step only until that word is taken.
`default_nettype none
module cwnd_delay_ecn_aimd_controller_unit
   import cwnd_pkg::*;
#(
   parameter int MSS_BYTES = 1500,
   parameter int CWND_MAX  = 16777215
) (
   input wire logic clock,
   input wire logic reset,
   cwnd_if.sink     req,
   cwnd_if.source   rsp,
   cwnd_if.sink     csr
);
   logic [47:0] base_rtt_ff, delay_thr_ff, to_holdoff_ff;
   logic [23:0] inc_gain_ff;
   logic [15:0] delay_dec_ff, ecn_gain_ff;
   logic [16:0] ewma_wt_ff;
   logic [1:0]  detect_ff;

   logic [2:0]  csr_idx;
   logic [47:0] csr_val;
   assign csr_idx   = csr.data[50:48];
   assign csr_val   = csr.data[47:0];
   assign csr.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_rtt_ff <= '0; delay_thr_ff <= '0; inc_gain_ff <= 24'd1500;
         delay_dec_ff <= '0; ecn_gain_ff <= '0; ewma_wt_ff <= '0;
         to_holdoff_ff <= '0; detect_ff <= 2'd3;
      end else if (csr.valid && csr.ready) begin
         case (csr_idx)
            REG_BASE_RTT:   base_rtt_ff   <= csr_val;
            REG_DELAY_THR:  delay_thr_ff  <= csr_val;
            REG_INC_GAIN:   inc_gain_ff   <= csr_val[23:0];
            REG_DELAY_DEC:  delay_dec_ff  <= csr_val[15:0];
            REG_ECN_GAIN:   ecn_gain_ff   <= csr_val[15:0];
            REG_EWMA_WT:    ewma_wt_ff    <= csr_val[16:0];
            REG_TO_HOLDOFF: to_holdoff_ff <= csr_val;
            REG_DETECT:     detect_ff     <= csr_val[1:0];
            default: ;
         endcase
      end
   end

   // front: queue of event words
   event_type q_out;
   logic      q_full, q_empty, q_pop;
   assign req.ready = !q_full && !reset;

   cwnd_queue u_queue (
      .clock(clock), .reset(reset), .push(req.valid && req.ready),
      .push_data(event_type'(req.data)), .full(q_full),
      .pop(q_pop), .pop_data(q_out), .empty(q_empty)
   );

   result_type res;
   cwnd_back #(.MSS_BYTES(MSS_BYTES), .CWND_MAX(CWND_MAX)) u_back (
      .clock(clock), .reset(reset), .ev_valid(!q_empty), .ev(q_out),
      .ev_pop(q_pop), .base_rtt(base_rtt_ff), .delay_thr(delay_thr_ff),
      .inc_gain(inc_gain_ff), .delay_dec(delay_dec_ff), .ecn_gain(ecn_gain_ff),
      .ewma_wt(ewma_wt_ff), .to_holdoff(to_holdoff_ff), .detect(detect_ff),
      .res_valid(rsp.valid), .res(res), .res_ready(rsp.ready)
   );
   assign rsp.data = res;

   // window always within its clamp when a result is shown
   a_win_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (res.window_bytes >= 24'(MSS_BYTES) &&
                     res.window_bytes <= 24'(CWND_MAX)))
      else $error("window outside clamp");
   // smoothed marked fraction never above one
   a_ewma_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> res.ecn_ewma_q16 <= Q16_ONE)
      else $error("ewma above one");
   // never pop the queue when it is empty
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop on empty queue");
endmodule
`default_nettype wire

[sv/cwnd_queue.sv]
// ----------------------------------------------------------------------------
// cwnd_queue: event queue
// Two-entry FIFO between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module cwnd_queue
   import cwnd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  event_type      push_data,
   output logic           full,
   input  wire logic      pop,
   output event_type      pop_data,
   output logic           empty
);
   event_type  mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

[sv/cwnd_div.sv]
// ----------------------------------------------------------------------------
// cwnd_div: restoring divider
// Unsigned 48/32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cwnd_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [47:0]      quotient
);
   logic [47:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   assign quotient = q_ff;
   assign done     = busy_ff && cnt_ff == 6'd0;

   always_comb begin
      trial   = {r_ff[31:0], q_ff[47]};
      q_in    = {q_ff[46:0], 1'b0};
      r_in    = trial;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            q_in    = q_ff;
            r_in    = r_ff;
         end else begin
            if (trial >= {1'b0, d_ff}) begin
               r_in    = trial - {1'b0, d_ff};
               q_in[0] = 1'b1;
            end
            cnt_in = cnt_ff - 6'd1;
         end
      end else begin
         q_in = q_ff;
         r_in = r_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) begin
         d_ff <= divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end
endmodule
`default_nettype wire

[sv/cwnd_back.sv]
// ----------------------------------------------------------------------------
// cwnd_back: window update engine
// Sequencer that applies one event to the flow state and emits one result.
// ----------------------------------------------------------------------------
`default_nettype none
module cwnd_back
   import cwnd_pkg::*;
#(
   parameter int MSS_BYTES = 1500,
   parameter int CWND_MAX  = 16777215
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        ev_valid,
   input  event_type        ev,
   output logic             ev_pop,
   input  wire logic [47:0] base_rtt,
   input  wire logic [47:0] delay_thr,
   input  wire logic [23:0] inc_gain,
   input  wire logic [15:0] delay_dec,
   input  wire logic [15:0] ecn_gain,
   input  wire logic [16:0] ewma_wt,
   input  wire logic [47:0] to_holdoff,
   input  wire logic [1:0]  detect,
   output logic             res_valid,
   output result_type       res,
   input  wire logic        res_ready
);
   localparam logic [23:0] MSS  = 24'(MSS_BYTES);
   localparam logic [23:0] WMAX = 24'(CWND_MAX);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ROUND = 4'd1;
   localparam logic [3:0] S_FDIV  = 4'd2;
   localparam logic [3:0] S_EWMA1 = 4'd3;
   localparam logic [3:0] S_EWMA2 = 4'd4;
   localparam logic [3:0] S_RTT   = 4'd5;
   localparam logic [3:0] S_GROW  = 4'd6;
   localparam logic [3:0] S_IDIV  = 4'd7;
   localparam logic [3:0] S_CUT1  = 4'd8;
   localparam logic [3:0] S_CUT2  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0]  st_ff, st_in;
   event_type   ev_ff;
   logic [23:0] win_ff, win_in, ssth_ff, ssth_in;
   logic        slow_ff, slow_in;
   logic [31:0] racked_ff, racked_in, rmark_ff, rmark_in;
   logic [47:0] rstart_ff, rstart_in, lcut_ff, lcut_in, lto_ff, lto_in;
   logic [47:0] minrtt_ff, minrtt_in;
   logic [16:0] ewma_ff, ewma_in;
   logic        cut_ff, cut_in, econg_ff, econg_in, rcong_ff, rcong_in;
   logic [16:0] tmp_ff, tmp_in;      // frac, then factor
   logic [33:0] prod_ff, prod_in;
   logic        res_valid_ff, res_valid_in;
   result_type  res_ff, res_in;

   logic        div_start, div_done;
   logic [47:0] div_num, div_q;
   logic [31:0] div_den;

   cwnd_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? CNT_MAX : s[31:0];
   endfunction

   function automatic logic [23:0] clampw(input logic [24:0] w);
      logic [24:0] v;
      v = w;
      if (v < {1'b0, MSS}) v = {1'b0, MSS};
      if (v > {1'b0, WMAX}) v = {1'b0, WMAX};
      return v[23:0];
   endfunction

   logic [16:0] wclip;
   logic [47:0] el_round, el_cut, el_to;
   logic [48:0] thr_sum;
   logic [33:0] ewma_a;
   logic [16:0] fe, fsel;
   logic [40:0] grow_prod;
   logic [24:0] wsum;
   logic [40:0] cut_prod;

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   always_comb begin
      wclip     = (ewma_wt > Q16_ONE) ? Q16_ONE : ewma_wt;
      el_round  = ev_ff.now_time - rstart_ff;
      el_cut    = ev_ff.now_time - lcut_ff;
      el_to     = ev.now_time - lto_ff;
      thr_sum   = {1'b0, base_rtt} + {1'b0, delay_thr};
      ewma_a    = {17'd0, Q16_ONE - wclip} * {17'd0, ewma_ff};
      fe        = econg_ff ? 17'(prod_ff[33:16]) : 17'd0;
      fsel      = fe;
      if (rcong_ff && {1'b0, delay_dec} > fsel) fsel = {1'b0, delay_dec};
      if (fsel > Q16_ONE) fsel = Q16_ONE;
      grow_prod = {17'd0, inc_gain} * {25'd0, ev_ff.acked_bytes};
      wsum      = {1'b0, win_ff} + {9'd0, ev_ff.acked_bytes};
      cut_prod  = {17'd0, win_ff} * {24'd0, Q16_ONE - tmp_ff};

      st_in = st_ff; win_in = win_ff; ssth_in = ssth_ff; slow_in = slow_ff;
      racked_in = racked_ff; rmark_in = rmark_ff; rstart_in = rstart_ff;
      lcut_in = lcut_ff; lto_in = lto_ff; minrtt_in = minrtt_ff;
      ewma_in = ewma_ff; cut_in = cut_ff; econg_in = econg_ff;
      rcong_in = rcong_ff; tmp_in = tmp_ff; prod_in = prod_ff;
      res_valid_in = res_valid_ff; res_in = res_ff;
      ev_pop = 1'b0; div_start = 1'b0; div_num = '0; div_den = '0;

      if (res_valid_ff && res_ready) res_valid_in = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (ev_valid) begin
               ev_pop = 1'b1;
               cut_in = 1'b0;
               case (ev.cmd)
                  CMD_ACK: begin
                     econg_in  = detect[0] && ev.ecn_mark;
                     racked_in = sat_add(racked_ff, ev.acked_bytes);
                     if (detect[0] && ev.ecn_mark)
                        rmark_in = sat_add(rmark_ff, ev.acked_bytes);
                     st_in = S_ROUND;
                  end
                  CMD_TIMEOUT: begin
                     if (el_to > to_holdoff) begin
                        slow_in = 1'b1; ssth_in = {1'b0, win_ff[23:1]};
                        win_in = clampw({1'b0, MSS}); rstart_in = ev.now_time;
                        racked_in = '0; rmark_in = '0; minrtt_in = '0;
                        lcut_in = ev.now_time; lto_in = ev.now_time;
                        cut_in = 1'b1;
                     end
                     st_in = S_OUT;
                  end
                  CMD_FIRST: begin
                     if (rstart_ff == '0 || lcut_ff == '0) begin
                        lcut_in = ev.now_time; rstart_in = ev.now_time;
                        racked_in = '0; rmark_in = '0; minrtt_in = '0;
                     end
                     st_in = S_OUT;
                  end
                  default: st_in = S_OUT;
               endcase
            end
         end
         S_ROUND: begin
            if (rstart_ff != '0 && el_round > base_rtt) begin
               rstart_in = ev_ff.now_time;
               if (racked_ff != '0) begin
                  div_start = 1'b1;
                  div_num   = {rmark_ff, 16'd0};
                  div_den   = racked_ff;
                  st_in     = S_FDIV;
               end else begin
                  tmp_in = '0;
                  st_in  = S_EWMA1;
               end
            end else begin
               st_in = S_RTT;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               tmp_in = (div_q > 48'(Q16_ONE)) ? Q16_ONE : div_q[16:0];
               st_in  = S_EWMA1;
            end
         end
         S_EWMA1: begin
            prod_in = {17'd0, wclip} * {17'd0, tmp_ff};
            st_in   = S_EWMA2;
         end
         S_EWMA2: begin
            ewma_in = 17'((ewma_a + prod_ff) >> 16);
            if ({1'b0, ewma_in} > {1'b0, Q16_ONE}) ewma_in = Q16_ONE;
            racked_in = '0; rmark_in = '0; minrtt_in = '0;
            st_in = S_RTT;
         end
         S_RTT: begin
            if (minrtt_ff == '0 || ev_ff.rtt_sample < minrtt_ff)
               minrtt_in = ev_ff.rtt_sample;
            rcong_in = detect[1] && ({1'b0, minrtt_in} > thr_sum);
            if (slow_ff && win_ff >= ssth_ff) begin
               ssth_in = '0; slow_in = 1'b0;
            end
            prod_in = {17'd0, ewma_ff} * {18'd0, ecn_gain};
            st_in   = S_GROW;
         end
         S_GROW: begin
            if (!rcong_ff && !econg_ff) begin
               if (slow_ff) begin
                  win_in = clampw(wsum);
                  st_in  = S_OUT;
               end else begin
                  div_start = 1'b1;
                  div_num   = {7'd0, grow_prod};
                  div_den   = {8'd0, win_ff};
                  st_in     = S_IDIV;
               end
            end else if (lcut_ff != '0 && el_cut > base_rtt) begin
               tmp_in = fsel;
               st_in  = S_CUT1;
            end else begin
               win_in = clampw({1'b0, win_ff});
               st_in  = S_OUT;
            end
         end
         S_IDIV: begin
            if (div_done) begin
               win_in = clampw(25'({1'b0, win_ff} + div_q[24:0]) |
                               ((div_q[47:24] != '0) ? 25'h1FFFFFF : 25'd0));
               st_in  = S_OUT;
            end
         end
         S_CUT1: begin
            win_in    = clampw(25'(cut_prod >> 16));
            lcut_in   = ev_ff.now_time;
            rstart_in = ev_ff.now_time;
            cut_in    = 1'b1;
            st_in     = S_OUT;
         end
         S_OUT: begin
            // load the result register once the previous word has gone
            if (!res_valid_ff || res_ready) begin
               res_valid_in                = 1'b1;
               res_in.window_bytes         = win_ff;
               res_in.slow_start_threshold = ssth_ff;
               res_in.in_slow_start        = slow_ff;
               res_in.ecn_ewma_q16         = ewma_ff;
               res_in.window_cut           = cut_ff;
               st_in                       = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ev_pop) ev_ff <= ev;
      tmp_ff  <= tmp_in;
      prod_ff <= prod_in;
      econg_ff <= econg_in;
      rcong_ff <= rcong_in;
      cut_ff  <= cut_in;
      res_ff  <= res_in;
      if (reset) begin
         st_ff <= S_IDLE; win_ff <= clampw({1'b0, MSS}); ssth_ff <= WMAX;
         slow_ff <= 1'b1; racked_ff <= '0; rmark_ff <= '0; rstart_ff <= '0;
         lcut_ff <= '0; lto_ff <= '0; minrtt_ff <= '0; ewma_ff <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in; win_ff <= win_in; ssth_ff <= ssth_in;
         slow_ff <= slow_in; racked_ff <= racked_in; rmark_ff <= rmark_in;
         rstart_ff <= rstart_in; lcut_ff <= lcut_in; lto_ff <= lto_in;
         minrtt_ff <= minrtt_in; ewma_ff <= ewma_in;
         res_valid_ff <= res_valid_in;
      end
   end
endmodule
`default_nettype wire
